// File: rtl/tksc_pkg.sv
// Shared types and constants for the timed key sequence controller.
// No dependencies; the controller imports this package (tksc_if.sv does not).
package tksc_pkg;

  // Host command codes
  localparam logic [1:0] CMD_NONE   = 2'd0;
  localparam logic [1:0] CMD_ON     = 2'd1;
  localparam logic [1:0] CMD_OFF    = 2'd2;
  localparam logic [1:0] CMD_TOGGLE = 2'd3;

  // Key click codes
  localparam logic [1:0] KEY_NONE  = 2'd0;
  localparam logic [1:0] KEY_CTRL  = 2'd1;
  localparam logic [1:0] KEY_SHIFT = 2'd2;

  // Config register map (index = paddr[4:2])
  localparam int unsigned CFG_AW = 5;
  localparam logic [2:0] REG_DEBOUNCE = 3'd0;
  localparam logic [2:0] REG_BLINK    = 3'd1;
  localparam logic [2:0] REG_GAP_ONE  = 3'd2;
  localparam logic [2:0] REG_GAP_TWO  = 3'd3;
  localparam logic [2:0] REG_GAP_THR  = 3'd4;
  localparam logic [2:0] REG_TAIL     = 3'd5;

  // Reset values of the config registers
  localparam logic [9:0]  DEBOUNCE_RST = 10'd50;
  localparam logic [9:0]  BLINK_RST    = 10'd50;
  localparam logic [15:0] GAP_ONE_RST  = 16'd1000;
  localparam logic [15:0] GAP_TWO_RST  = 16'd2000;
  localparam logic [15:0] GAP_THR_RST  = 16'd1500;
  localparam logic [15:0] TAIL_RST     = 16'd100;

  // Seconds to ticks
  localparam logic [9:0] WAIT_SCALE = 10'd1000;

  // Sequence step: named by the event that ends the step
  typedef enum logic [2:0] {
    STEP_START = 3'd0,   // control click on the next tick
    STEP_GAP1  = 3'd1,   // wait gap one, then shift
    STEP_GAP2  = 3'd2,   // wait gap two, then control
    STEP_GAP3  = 3'd3,   // wait gap three, then shift
    STEP_TAIL  = 3'd4    // final pause
  } seq_step_t;

  typedef struct packed {
    logic       led_on;
    logic [1:0] key_click;
    logic       is_active;
    logic       is_emulating;
  } tksc_res_t;

endpackage

// File: rtl/tksc_if.sv
// Valid/ready channel interfaces: tick word in, status word out.
// No dependencies.
interface tksc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic       button_pressed;
  logic [4:0] random_seconds;

  modport source (output valid, command, button_pressed, random_seconds, input ready);
  modport sink   (input valid, command, button_pressed, random_seconds, output ready);
endinterface

interface tksc_out_if;
  logic       valid;
  logic       ready;
  logic       led_on;
  logic [1:0] key_click;
  logic       is_active;
  logic       is_emulating;

  modport source (output valid, led_on, key_click, is_active, is_emulating, input ready);
  modport sink   (input valid, led_on, key_click, is_active, is_emulating, output ready);
endinterface

// File: rtl/timed_key_sequence_controller.sv
// Timed key sequence controller: debounce, mode control, key sequencer.
// Depends on tksc_pkg and the channel interfaces in tksc_if.sv.
//
// Usage:
//   in_ch carries one word per millisecond tick: host command, raw button
//   level and a random wait in seconds. out_ch returns one word per tick:
//   LED level, key clicked this tick, active and emulating flags.
//   cfg_* is an APB-style write/read port for six timing registers at
//   byte addresses 0,4,..,20; write them only while the block is idle.
// Timing:
//   One tick word is taken per clock while in_ch.ready is high. Its result
//   is registered into the output stage (head, or skid while the head waits)
//   on acceptance. All per-tick work is a single pass of counters and compares feeding the state and output registers.
// Stalls:
//   A two-entry output stage (head plus skid) lets a tick be taken while a
//   finished result waits; in_ch.ready drops only when both are full.
// Reset:
//   rst_n (synchronous, active low) clears mode, sequencer and counters and
//   loads the register defaults; no clearing pass is needed.
module timed_key_sequence_controller
  import tksc_pkg::*;
#(
  parameter int TIMER_BITS = 16   // elapsed-time counter width, 12..32
) (
  input  logic               clk,
  input  logic               rst_n,
  tksc_in_if.sink            in_ch,
  tksc_out_if.source         out_ch,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [CFG_AW-1:0]  cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  localparam int TW = TIMER_BITS;
  // compare widths: counter against a 16-bit gap / 15-bit wait target
  localparam int GW = (TW > 16) ? TW : 16;
  localparam int WW = (TW > 15) ? TW : 15;

  // ---------------------------------------------------------------- config
  logic [9:0]  deb_r, blink_half_r;
  logic [15:0] gap1_r, gap2_r, gap3_r, tail_r;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_r        <= DEBOUNCE_RST;
      blink_half_r <= BLINK_RST;
      gap1_r       <= GAP_ONE_RST;
      gap2_r       <= GAP_TWO_RST;
      gap3_r       <= GAP_THR_RST;
      tail_r       <= TAIL_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_DEBOUNCE: deb_r        <= cfg_pwdata[9:0];
        REG_BLINK:    blink_half_r <= cfg_pwdata[9:0];
        REG_GAP_ONE:  gap1_r       <= cfg_pwdata[15:0];
        REG_GAP_TWO:  gap2_r       <= cfg_pwdata[15:0];
        REG_GAP_THR:  gap3_r       <= cfg_pwdata[15:0];
        REG_TAIL:     tail_r       <= cfg_pwdata[15:0];
        default: ;   // unmapped, dropped
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_DEBOUNCE: cfg_prdata = {22'd0, deb_r};
      REG_BLINK:    cfg_prdata = {22'd0, blink_half_r};
      REG_GAP_ONE:  cfg_prdata = {16'd0, gap1_r};
      REG_GAP_TWO:  cfg_prdata = {16'd0, gap2_r};
      REG_GAP_THR:  cfg_prdata = {16'd0, gap3_r};
      REG_TAIL:     cfg_prdata = {16'd0, tail_r};
      default:      cfg_prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------- state
  logic          act_r, emu_r, led_r, raw_r, stable_r;
  seq_step_t     step_r;
  logic [TW-1:0] step_el_r, blink_el_r, idle_el_r, since_r;
  logic [14:0]   wait_r;

  logic          act_nxt, emu_nxt, led_nxt, stable_nxt;
  seq_step_t     step_nxt;
  logic [TW-1:0] step_el_nxt, blink_el_nxt, idle_el_nxt, since_nxt;
  logic [14:0]   wait_nxt;

  // after command and debounce, before blink/sequence
  logic          act_m, emu_m, led_m;
  seq_step_t     step_m;
  logic [TW-1:0] idle_m;
  logic [14:0]   wait_m;

  logic [TW-1:0] step_inc, blink_inc, idle_inc, since_inc;
  logic [14:0]   wait_arm;
  logic          set_req, set_val, step_go;
  logic [1:0]    click;

  logic          in_fire;
  logic          btn;
  logic [1:0]    cmd;

  assign btn = in_ch.button_pressed;
  assign cmd = in_ch.command;

  // saturating tick counters
  assign step_inc  = (step_el_r  == '1) ? step_el_r  : step_el_r  + TW'(1);
  assign blink_inc = (blink_el_r == '1) ? blink_el_r : blink_el_r + TW'(1);
  assign idle_inc  = (idle_el_r  == '1) ? idle_el_r  : idle_el_r  + TW'(1);
  assign since_inc = (since_r    == '1) ? since_r    : since_r    + TW'(1);

  // new wait in ticks: 0..31000 fits 15 bits
  assign wait_arm = 15'(in_ch.random_seconds) * 15'(WAIT_SCALE);

  // host command, then debounce; both may flip the mode in one tick
  always_comb begin
    act_m      = act_r;
    emu_m      = emu_r;
    led_m      = led_r;
    step_m     = step_r;
    idle_m     = idle_inc;
    wait_m     = wait_r;
    since_nxt  = since_inc;
    stable_nxt = stable_r;
    set_req    = 1'b0;
    set_val    = 1'b0;

    case (cmd)
      CMD_ON:     begin set_req = !act_r; set_val = 1'b1;   end
      CMD_OFF:    begin set_req = act_r;  set_val = 1'b0;   end
      CMD_TOGGLE: begin set_req = 1'b1;   set_val = !act_r; end
      default:    ;
    endcase

    if (set_req) begin
      act_m = set_val;
      if (set_val) begin
        led_m  = 1'b1;
        idle_m = '0;
        wait_m = wait_arm;
      end else begin
        emu_m  = 1'b0;
        step_m = STEP_START;
        led_m  = 1'b0;
      end
    end

    if (btn != raw_r) since_nxt = '0;
    if (since_nxt > TW'(deb_r) && btn != stable_r) begin
      stable_nxt = btn;
      if (btn) begin
        act_m = !act_m;
        if (act_m) begin
          led_m  = 1'b1;
          idle_m = '0;
          wait_m = wait_arm;
        end else begin
          emu_m  = 1'b0;
          step_m = STEP_START;
          led_m  = 1'b0;
        end
      end
    end
  end

  // step completion test
  always_comb begin
    case (step_m)
      STEP_START: step_go = 1'b1;
      STEP_GAP1:  step_go = GW'(step_inc) >= GW'(gap1_r);
      STEP_GAP2:  step_go = GW'(step_inc) >= GW'(gap2_r);
      STEP_GAP3:  step_go = GW'(step_inc) >= GW'(gap3_r);
      default:    step_go = GW'(step_inc) >= GW'(tail_r);  // tail and unused codes
    endcase
  end

  // click output decode
  always_comb begin
    click = KEY_NONE;
    if (emu_m && step_go) begin
      case (step_m)
        STEP_START: click = KEY_CTRL;
        STEP_GAP1:  click = KEY_SHIFT;
        STEP_GAP2:  click = KEY_CTRL;
        STEP_GAP3:  click = KEY_SHIFT;
        default:    click = KEY_NONE;
      endcase
    end
  end

  // blink, sequence advance, sequence start
  always_comb begin
    act_nxt      = act_m;
    emu_nxt      = emu_m;
    led_nxt      = led_m;
    step_nxt     = step_m;
    step_el_nxt  = step_inc;
    blink_el_nxt = blink_inc;
    idle_el_nxt  = idle_m;
    wait_nxt     = wait_m;

    if (emu_m && blink_inc >= TW'(blink_half_r)) begin
      blink_el_nxt = '0;
      led_nxt      = !led_m;
    end

    if (emu_m && step_go) begin
      case (step_m)
        STEP_START: begin step_nxt = STEP_GAP1; step_el_nxt = '0; end
        STEP_GAP1:  begin step_nxt = STEP_GAP2; step_el_nxt = '0; end
        STEP_GAP2:  begin step_nxt = STEP_GAP3; step_el_nxt = '0; end
        STEP_GAP3:  begin step_nxt = STEP_TAIL; step_el_nxt = '0; end
        default: begin
          emu_nxt  = 1'b0;
          step_nxt = STEP_START;
          led_nxt  = 1'b1;
        end
      endcase
    end

    // same tick may restart once the wait has run out
    if (act_m && !emu_nxt && WW'(idle_m) >= WW'(wait_m)) begin
      idle_el_nxt  = '0;
      wait_nxt     = wait_arm;
      emu_nxt      = 1'b1;
      step_nxt     = STEP_START;
      led_nxt      = 1'b1;
      blink_el_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r      <= 1'b0;
      emu_r      <= 1'b0;
      led_r      <= 1'b0;
      raw_r      <= 1'b0;
      stable_r   <= 1'b0;
      step_r     <= STEP_START;
      step_el_r  <= '0;
      blink_el_r <= '0;
      idle_el_r  <= '0;
      since_r    <= '0;
      wait_r     <= '0;
    end else if (in_fire) begin
      act_r      <= act_nxt;
      emu_r      <= emu_nxt;
      led_r      <= led_nxt;
      raw_r      <= btn;
      stable_r   <= stable_nxt;
      step_r     <= step_nxt;
      step_el_r  <= step_el_nxt;
      blink_el_r <= blink_el_nxt;
      idle_el_r  <= idle_el_nxt;
      since_r    <= since_nxt;
      wait_r     <= wait_nxt;
    end
  end

  // ---------------------------------------------------------------- output
  tksc_res_t res;
  tksc_res_t head_r, skid_r;
  logic      head_vld_r, skid_vld_r;
  logic      out_pop;

  assign res.led_on       = led_nxt;
  assign res.key_click    = click;
  assign res.is_active    = act_nxt;
  assign res.is_emulating = emu_nxt;

  assign in_ch.ready = !skid_vld_r;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_pop     = head_vld_r && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_pop || !head_vld_r) begin
      if (skid_vld_r) begin
        head_vld_r <= 1'b1;
        skid_vld_r <= in_fire;
      end else begin
        head_vld_r <= in_fire;
      end
    end else if (in_fire) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_pop || !head_vld_r) begin
      if (skid_vld_r) begin
        head_r <= skid_r;
        if (in_fire) skid_r <= res;
      end else if (in_fire) begin
        head_r <= res;
      end
    end else if (in_fire) begin
      skid_r <= res;
    end
  end

  assign out_ch.valid        = head_vld_r;
  assign out_ch.led_on       = head_r.led_on;
  assign out_ch.key_click    = head_r.key_click;
  assign out_ch.is_active    = head_r.is_active;
  assign out_ch.is_emulating = head_r.is_emulating;

  // ---------------------------------------------------------------- checks
  a_skid_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> head_vld_r)
    else $error("skid word held without a head word");

  a_emu_needs_active: assert property (@(posedge clk) disable iff (!rst_n)
    emu_r |-> act_r)
    else $error("sequence running while mode inactive");

  a_led_off_inactive: assert property (@(posedge clk) disable iff (!rst_n)
    !act_r |-> !led_r)
    else $error("LED lit while mode inactive");

  a_step_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    !emu_r |-> step_r == STEP_START)
    else $error("sequencer left mid-step while stopped");

  a_no_drop_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_vld_r && !out_ch.ready) |=> skid_vld_r && head_vld_r)
    else $error("buffered word lost while output stalled");

endmodule
